>>> rtl/cbs_pkg.sv
// Shared types for the cubic B-spline sampler: sequencer states, datapath
// phases and the command/status records between controller and datapath.
// No dependencies.
package cbs_pkg;

    // Q0.16 parameter t
    localparam int T_W         = 16;
    localparam int STEP_W      = 16;
    localparam logic [STEP_W-1:0] STEP_MIN   = 16'd1024;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd4096;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [3:0]
    {
        PH_SQUARE,
        PH_CUBE,
        PH_POLY,
        PH_ROUND,
        PH_DIV,
        PH_MAC0,
        PH_MAC1,
        PH_MAC2,
        PH_MAC3,
        PH_EMIT
    } phase_t;

    typedef struct packed
    {
        logic       fill;       // store point into window slot fill_idx
        logic [1:0] fill_idx;
        logic       take_p3;    // latch closing point, t = 0
        logic       run;        // phase below is active
        phase_t     phase;
        logic       emit;       // load output register, advance t
        logic       slide;      // shift window by one point
    } cbs_cmd_t;

    typedef struct packed
    {
        logic last;     // current sample is the final one of the segment
        logic out_busy; // output register full and not being taken
    } cbs_stat_t;

endpackage

>>> rtl/cbs_ctrl.sv
// Sequencer for the cubic B-spline sampler: window fill count and the
// per-sample phase walk. Depends on cbs_pkg.
module cbs_ctrl
    import cbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      first_of_curve,
    input  cbs_stat_t stat,
    output cbs_cmd_t  cmd
);

    state_t     state_reg, state_next;
    phase_t     ph_reg, ph_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] cnt_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= PH_SQUARE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        cnt_next     = cnt_reg;
        s_tready     = 1'b0;
        cnt_eff      = first_of_curve ? 2'd0 : cnt_reg;
        cmd          = '0;
        cmd.phase    = ph_reg;
        cmd.fill_idx = cnt_eff;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (cnt_eff != 2'd3)
                    begin
                        cmd.fill = 1'b1;
                        cnt_next = cnt_eff + 2'd1;
                    end
                    else
                    begin
                        cmd.take_p3 = 1'b1;
                        cnt_next    = 2'd3;
                        ph_next     = PH_SQUARE;
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
                if (ph_reg != PH_EMIT)
                begin
                    ph_next = phase_t'(ph_reg + 4'd1);
                end
                else if (!stat.out_busy)
                begin
                    cmd.emit = 1'b1;
                    ph_next  = PH_SQUARE;
                    if (stat.last)
                    begin
                        cmd.slide  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/cbs_datapath.sv
// Datapath of the cubic B-spline sampler: point window, basis weights,
// six MAC lanes and the output register. Depends on cbs_pkg.
module cbs_datapath
    import cbs_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cbs_cmd_t                 cmd,
    output cbs_stat_t                stat,
    input  logic                     cfg_wen,
    input  logic [STEP_W-1:0]        cfg_wdata,
    input  logic [3*COORD_WIDTH-1:0] pt_in,     // x, y, z from bit 0 up
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [6*COORD_WIDTH-1:0] out_data,  // pos x,y,z, tan x,y,z
    output logic                     out_last
);

    localparam int CW    = COORD_WIDTH;
    localparam int WFRAC = ((60 - CW) < 30) ? (60 - CW) : 30;
    localparam int DSH   = 48 - WFRAC;
    localparam int YSH   = 33 - WFRAC;
    localparam int QW    = WFRAC + 3;
    localparam int WW    = WFRAC + 2;
    localparam int RN    = QW + 2;
    localparam int XW    = 52;
    localparam int YW    = 36;
    localparam int ACC_W = 64;
    localparam logic [RN-1:0] RECIP3 = RN'(((64'd1 << RN) + 64'd2) / 64'd3);
    localparam logic signed [XW-1:0] X_RND = XW'(64'd3 << DSH);
    localparam logic signed [YW-1:0] Y_RND = YW'(64'd1 << (YSH - 1));
    localparam logic signed [ACC_W-1:0] A_RND = ACC_W'(64'd1 << (WFRAC - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic [STEP_W-1:0] step_cfg_reg;
    logic [STEP_W-1:0] step_eff;
    logic [T_W-1:0]    t_reg;
    logic [T_W:0]      t_sum;

    logic signed [CW-1:0] win_reg [4][3];   // slots 0..2 window, 3 closing point

    logic [T_W:0]  u_c;
    logic [T_W:0]  u_reg;
    logic [31:0]   t2_reg;
    logic [33:0]   u2_reg;
    logic [47:0]   t3_reg;
    logic [48:0]   u3_reg;

    logic signed [XW-1:0] x_reg [4];
    logic signed [YW-1:0] y_reg [4];
    logic [QW-1:0]        q_reg [4];
    logic signed [WW-1:0] wp_reg [4];
    logic signed [WW-1:0] wt_reg [4];

    logic signed [ACC_W-1:0] accp_reg [3];
    logic signed [ACC_W-1:0] acct_reg [3];

    logic                 valid_reg;
    logic [6*CW-1:0]      data_reg;
    logic                 last_reg;

    logic signed [XW-1:0] t3s, t2s16, t32, u3s;
    logic signed [YW-1:0] t2y, t17, u2y;
    logic [1:0]           mac_idx;
    logic                 mac_on;
    logic [6*CW-1:0]      data_c;

    assign step_eff = (step_cfg_reg < STEP_MIN) ? STEP_MIN : step_cfg_reg;
    assign t_sum    = {1'b0, t_reg} + {1'b0, step_eff};
    assign u_c      = (T_W+1)'(1 << T_W) - {1'b0, t_reg};

    assign t3s   = XW'(t3_reg);
    assign t2s16 = XW'({t2_reg, 16'd0});
    assign t32   = XW'({t_reg, 32'd0});
    assign u3s   = XW'(u3_reg);
    assign t2y   = YW'(t2_reg);
    assign t17   = YW'({t_reg, 17'd0});
    assign u2y   = YW'(u2_reg);

    always_comb
    begin
        mac_on  = cmd.run;
        mac_idx = 2'd0;
        case (cmd.phase)
            PH_MAC0: mac_idx = 2'd0;
            PH_MAC1: mac_idx = 2'd1;
            PH_MAC2: mac_idx = 2'd2;
            PH_MAC3: mac_idx = 2'd3;
            default: mac_on  = 1'b0;
        endcase
    end

    // round the accumulators and clamp to the coordinate range
    always_comb
    begin
        logic signed [ACC_W-1:0] rp, rt;
        for (int k = 0; k < 3; k++)
        begin
            rp = (accp_reg[k] + A_RND) >>> WFRAC;
            rt = (acct_reg[k] + A_RND) >>> WFRAC;
            if (rp > SAT_HI)      rp = SAT_HI;
            else if (rp < SAT_LO) rp = SAT_LO;
            if (rt > SAT_HI)      rt = SAT_HI;
            else if (rt < SAT_LO) rt = SAT_LO;
            data_c[k*CW +: CW]       = rp[CW-1:0];
            data_c[(k+3)*CW +: CW]   = rt[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg <= STEP_RESET;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                step_cfg_reg <= cfg_wdata;
            if (cmd.emit)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            for (int k = 0; k < 3; k++)
                win_reg[cmd.fill_idx][k] <= pt_in[k*CW +: CW];
        end
        if (cmd.take_p3)
        begin
            for (int k = 0; k < 3; k++)
                win_reg[3][k] <= pt_in[k*CW +: CW];
            t_reg <= '0;
        end
        if (cmd.slide)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[0][k] <= win_reg[1][k];
                win_reg[1][k] <= win_reg[2][k];
                win_reg[2][k] <= win_reg[3][k];
            end
        end
        if (cmd.emit)
        begin
            data_reg <= data_c;
            last_reg <= t_sum[T_W];
            t_reg    <= t_sum[T_W-1:0];
        end

        if (cmd.run)
        begin
            case (cmd.phase)
                PH_SQUARE:
                begin
                    u_reg  <= u_c;
                    t2_reg <= t_reg * t_reg;
                    u2_reg <= u_c * u_c;
                end
                PH_CUBE:
                begin
                    t3_reg <= t2_reg * t_reg;
                    u3_reg <= u2_reg * u_reg;
                end
                PH_POLY:
                begin
                    x_reg[0] <= u3s;
                    x_reg[1] <= XW'(3) * t3s - XW'(6) * t2s16 + XW'(64'd1 << 50);
                    x_reg[2] <= -(XW'(3) * t3s) + XW'(3) * t2s16 + XW'(3) * t32
                                + XW'(64'd1 << 48);
                    x_reg[3] <= t3s;
                    y_reg[0] <= -u2y;
                    y_reg[1] <= YW'(3) * t2y - (t17 <<< 1);
                    y_reg[2] <= -(YW'(3) * t2y) + t17 + YW'(64'd1 << 32);
                    y_reg[3] <= t2y;
                end
                PH_ROUND:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        logic signed [XW-1:0] xr;
                        logic signed [YW-1:0] yr;
                        xr        = x_reg[i] + X_RND;
                        yr        = y_reg[i] + Y_RND;
                        q_reg[i]  <= xr[DSH+QW:DSH+1];
                        wt_reg[i] <= yr[YSH+WW-1:YSH];
                    end
                end
                PH_DIV:
                begin
                    // divide by three through the reciprocal
                    for (int i = 0; i < 4; i++)
                    begin
                        logic [QW+RN-1:0] pr;
                        pr         = q_reg[i] * RECIP3;
                        wp_reg[i] <= pr[RN+WW-1:RN];
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (mac_on)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [WW+CW-1:0] pp, pt;
                pp = wp_reg[mac_idx] * win_reg[mac_idx][k];
                pt = wt_reg[mac_idx] * win_reg[mac_idx][k];
                accp_reg[k] <= ((mac_idx == 2'd0) ? '0 : accp_reg[k]) + ACC_W'(pp);
                acct_reg[k] <= ((mac_idx == 2'd0) ? '0 : acct_reg[k]) + ACC_W'(pt);
            end
        end
    end

    assign stat.last     = t_sum[T_W];
    assign stat.out_busy = valid_reg && !out_ready;
    assign out_valid     = valid_reg;
    assign out_data      = data_reg;
    assign out_last      = last_reg;

endmodule

>>> rtl/cubic_bspline_sampler.sv
// Cubic B-spline sampler top level over cbs_ctrl and cbs_datapath (cbs_pkg).
// A point that fills the window is only stored in its slot. A point that closes a
// segment gives ceil(65536/step) samples, one per phase walk (five
// weight stages, four MAC steps, one round/clamp), each waiting at the round/clamp
// step while the output register is full; input is held off until the last sample.
// rst_n (asynchronous, active low) empties the window, sets t_step to 4096.
module cubic_bspline_sampler
    import cbs_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration: t_step, Q0.16
    input  logic                                   cfg_wen,
    input  logic [STEP_W-1:0]                      cfg_wdata,
    // control point items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,  // pt_x, pt_y, pt_z
    input  logic                                   s_tuser,  // first_of_curve
    // sample items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,  // pos x,y,z, tan x,y,z
    output logic                                   m_tlast   // last_sample
);

    localparam int OUT_W = ((6*COORD_WIDTH+7)/8)*8;

    cbs_cmd_t              cmd;
    cbs_stat_t             stat;
    logic [6*COORD_WIDTH-1:0] samp;

    // Controller: takes a point when idle, runs the sample phases.
    cbs_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .first_of_curve (s_tuser),
        .stat           (stat),
        .cmd            (cmd)
    );

    // Datapath: window, weights, MAC lanes, output register. The output
    // register lets the next point be taken while the last sample waits.
    cbs_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .pt_in     (s_tdata[3*COORD_WIDTH-1:0]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (samp),
        .out_last  (m_tlast)
    );

    assign m_tdata = OUT_W'(samp);

endmodule
